// ----- rtl/core/baro_pressure_compensation_altitude_assert.svh -----
// assertion macros for the checker file
`ifndef BARO_PRESSURE_COMPENSATION_ALTITUDE_ASSERT_SVH
`define BARO_PRESSURE_COMPENSATION_ALTITUDE_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define BPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpc assertion failed");

// consequent must hold in the same cycle as the antecedent
`define BPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpc assertion failed");

`endif

// ----- rtl/core/bpc_pkg.sv -----
`default_nettype none

package bpc_pkg;

    localparam int RAW_W      = 24;
    localparam int S_TDATA_W  = 2 * RAW_W;
    localparam int M_TDATA_W  = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int C30_W      = 16;
    localparam int OSR_W      = 3;

    localparam int P16_W   = 22;
    localparam int T256_W  = 16;
    localparam int ALT_W   = 23;
    localparam int H_W     = 32;
    localparam int SC_W    = 32;
    localparam int M_PAD_W = M_TDATA_W - P16_W - T256_W - ALT_W;

    // scaled readings: |raw| * 2^26 / k, one quotient bit per step
    localparam int KDIV_W     = 23;
    localparam int FRAC_W     = 26;
    localparam int DIVIDEND_W = RAW_W + FRAC_W;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // shared multiplier: 54-bit operand split in two halves against 32 bits
    localparam int MUL_A_W   = 54;
    localparam int MUL_B_W   = 32;
    localparam int MUL_SPLIT = MUL_A_W / 2;
    localparam int MUL_X_W   = MUL_A_W - MUL_SPLIT + 1;
    localparam int PROD_W    = MUL_X_W + MUL_B_W;
    localparam int ACC_W     = MUL_A_W + MUL_B_W + 1;
    localparam int SUM_W     = 56;
    localparam int DIFF_W    = H_W + 1;

    localparam int P_SHIFT   = 12;
    localparam int ALT_SHIFT = 8;
    localparam int COEF_SHIFT = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CALIB_LOW  = 3'd0,
        REG_CALIB_HIGH = 3'd1,
        REG_C30        = 3'd2,
        REG_P_OSR      = 3'd3,
        REG_T_OSR      = 3'd4
    } cfg_reg_t;

    localparam logic [OSR_W-1:0] P_OSR_RESET = 3'd4;
    localparam logic [OSR_W-1:0] T_OSR_RESET = 3'd3;

    localparam logic signed [RAW_W-1:0]   D4_BASE  = 24'sd1616000;
    localparam logic signed [MUL_B_W-1:0] H_CUBE_K = 32'sd230808;

    localparam logic signed [ACC_W-1:0] SAT53_HI = {{(ACC_W-53){1'b0}}, {53{1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT53_LO = -SAT53_HI;

    localparam logic signed [SUM_W-1:0] T256_MIN = -56'sd32768;
    localparam logic signed [SUM_W-1:0] T256_MAX = 56'sd32767;
    localparam logic signed [SUM_W-1:0] H_MIN    = -56'sd2147483648;
    localparam logic signed [SUM_W-1:0] H_MAX    = 56'sd2147483647;
    localparam logic signed [SUM_W-1:0] P16_MAX  = 56'sd4194303;

    localparam logic signed [DIFF_W-1:0] ALT_MIN = -33'sd4194304;
    localparam logic signed [DIFF_W-1:0] ALT_MAX = 33'sd4194303;

    localparam logic [DIVIDEND_W-1:0] SC_POS_MAX = DIVIDEND_W'(64'd2147483647);
    localparam logic [DIVIDEND_W-1:0] SC_NEG_MAX = DIVIDEND_W'(64'd2147483648);

    typedef enum logic [2:0] {
        SH_8,
        SH_18,
        SH_20,
        SH_24,
        SH_26
    } shift_t;

    typedef enum logic [1:0] {
        PH_LO,
        PH_HI,
        PH_ADD,
        PH_OUT
    } mul_phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_P,
        S_DIV_T,
        S_MUL,
        S_WAIT,
        S_PRES,
        S_ALT
    } state_t;

    // one entry per pass through the multiplier
    typedef enum logic [3:0] {
        ST_TEMP,
        ST_Q1,
        ST_Q2,
        ST_Q3,
        ST_T1,
        ST_T2,
        ST_T3,
        ST_U,
        ST_SQ,
        ST_CUBE,
        ST_H
    } step_t;

    typedef struct packed {
        logic                      start;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
        shift_t                    sh;
    } mul_cmd_t;

    typedef struct packed {
        logic             start;
        logic [RAW_W-1:0] raw;
        logic [OSR_W-1:0] code;
    } div_cmd_t;

    function automatic logic [KDIV_W-1:0] osr_scale(input logic [OSR_W-1:0] code);
        case (code)
            3'd0:    return 23'd524288;
            3'd1:    return 23'd1572864;
            3'd2:    return 23'd3670016;
            3'd3:    return 23'd7864320;
            3'd4:    return 23'd253952;
            3'd5:    return 23'd516096;
            3'd6:    return 23'd1040384;
            3'd7:    return 23'd2088960;
            default: return 23'd524288;
        endcase
    endfunction

    function automatic logic signed [MUL_A_W-1:0] sat53(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        if (v > SAT53_HI) begin
            c = SAT53_HI;
        end
        else if (v < SAT53_LO) begin
            c = SAT53_LO;
        end
        else begin
            c = v;
        end
        return c[MUL_A_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bpc_div.sv -----
`default_nettype none

module bpc_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire bpc_pkg::div_cmd_t          cmd,
    output logic                            done,
    output logic signed [bpc_pkg::SC_W-1:0] quo
);
    import bpc_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic                  neg_reg;
    logic [KDIV_W-1:0]     k_reg;
    logic [KDIV_W-1:0]     rem_reg;
    logic [DIVIDEND_W-1:0] dq_reg;

    logic [RAW_W-1:0]      mag;
    logic [KDIV_W:0]       trial;
    logic [KDIV_W:0]       trial_sub;
    logic                  ge;

    assign mag       = cmd.raw[RAW_W-1] ? (RAW_W'(0) - cmd.raw) : cmd.raw;
    assign trial     = {rem_reg, dq_reg[DIVIDEND_W-1]};
    assign ge        = trial >= {1'b0, k_reg};
    assign trial_sub = trial - {1'b0, k_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge clk) begin
        if (cmd.start) begin
            neg_reg <= cmd.raw[RAW_W-1];
            k_reg   <= osr_scale(cmd.code);
            rem_reg <= '0;
            dq_reg  <= {mag, FRAC_W'(0)};
        end
        else if (busy_reg) begin
            rem_reg <= ge ? trial_sub[KDIV_W-1:0] : trial[KDIV_W-1:0];
            dq_reg  <= {dq_reg[DIVIDEND_W-2:0], ge};
        end
    end

    // truncate toward zero and saturate to 32 bits
    always_comb begin
        if (neg_reg) begin
            if (dq_reg > SC_NEG_MAX) begin
                quo = {1'b1, {(SC_W-1){1'b0}}};
            end
            else begin
                quo = SC_W'(0) - dq_reg[SC_W-1:0];
            end
        end
        else begin
            if (dq_reg > SC_POS_MAX) begin
                quo = {1'b0, {(SC_W-1){1'b1}}};
            end
            else begin
                quo = dq_reg[SC_W-1:0];
            end
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ----- rtl/core/bpc_mul.sv -----
`default_nettype none

module bpc_mul (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bpc_pkg::mul_cmd_t             cmd,
    output logic                               done,
    output logic signed [bpc_pkg::MUL_A_W-1:0] res
);
    import bpc_pkg::*;

    logic                      busy_reg;
    logic                      done_reg;
    mul_phase_t                phase_reg;
    logic signed [MUL_A_W-1:0] a_reg;
    logic signed [MUL_B_W-1:0] b_reg;
    shift_t                    sh_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [MUL_A_W-1:0] res_reg;

    logic signed [MUL_X_W-1:0] mul_x;
    logic signed [PROD_W-1:0]  prod_w;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   acc_sum;
    logic signed [ACC_W-1:0]   acc_sh;

    // low half is unsigned, high half carries the sign
    assign mul_x = (phase_reg == PH_LO) ?
                   $signed({1'b0, a_reg[MUL_SPLIT-1:0]}) :
                   $signed({a_reg[MUL_A_W-1], a_reg[MUL_A_W-1:MUL_SPLIT]});
    assign prod_w   = mul_x * b_reg;
    assign prod_ext = ACC_W'(prod_reg);
    assign acc_sum  = acc_reg + (prod_ext <<< MUL_SPLIT);

    always_comb begin
        case (sh_reg)
            SH_8:    acc_sh = acc_reg >>> 8;
            SH_18:   acc_sh = acc_reg >>> 18;
            SH_20:   acc_sh = acc_reg >>> 20;
            SH_24:   acc_sh = acc_reg >>> 24;
            SH_26:   acc_sh = acc_reg >>> 26;
            default: acc_sh = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= PH_LO;
        end
        else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg  <= 1'b1;
                phase_reg <= PH_LO;
            end
            else if (busy_reg) begin
                phase_reg <= mul_phase_t'(phase_reg + 2'd1);
                if (phase_reg == PH_OUT) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.start) begin
            a_reg  <= cmd.a;
            b_reg  <= cmd.b;
            sh_reg <= cmd.sh;
        end
        else if (busy_reg) begin
            case (phase_reg)
                PH_LO: begin
                    prod_reg <= prod_w;
                end
                PH_HI: begin
                    acc_reg  <= prod_ext;
                    prod_reg <= prod_w;
                end
                PH_ADD: begin
                    acc_reg <= acc_sum;
                end
                PH_OUT: begin
                    res_reg <= sat53(acc_sh);
                end
                default: begin
                    res_reg <= res_reg;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

// ----- rtl/core/baro_pressure_compensation_altitude.sv -----
`default_nettype none

// Barometric compensation: takes one raw pressure/temperature pair per transaction and
// returns compensated pressure (Pa x16), temperature (degC x256) and altitude in cm
// relative to a stored zero reference; a transaction with s_tuser set also makes its
// height the new reference and reports altitude zero. Calibration words and
// oversampling codes are to be written through the cfg port only while the block is idle;
// the block does not enforce this. While a transaction runs, s_tready is low: two
// restoring divisions scale the readings, then eleven passes go through the single shared
// 28x32 multiplier. The result sits in an output register, so the next transaction is
// accepted while it waits to be taken.
module baro_pressure_compensation_altitude (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // raw_pressure [23:0], raw_temperature [47:24]
    input  wire logic [bpc_pkg::S_TDATA_W-1:0]    s_tdata,
    // action: 0 measure, 1 measure and zero altitude
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // pressure_x16 [21:0], temperature_x256 [37:22], altitude_cm [60:38], zero pad
    output logic [bpc_pkg::M_TDATA_W-1:0]         m_tdata,
    input  wire logic                             cfg_wr_en,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bpc_pkg::*;

    // configuration
    logic [CFG_DATA_W-1:0] calib_low_reg;
    logic [CFG_DATA_W-1:0] calib_high_reg;
    logic [C30_W-1:0]      c30_reg;
    logic [OSR_W-1:0]      p_osr_reg;
    logic [OSR_W-1:0]      t_osr_reg;

    // control
    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   out_valid_reg, out_valid_next;
    logic signed [H_W-1:0] offset_reg, offset_next;

    // datapath
    logic                      action_reg, action_next;
    logic [RAW_W-1:0]          raw_t_reg, raw_t_next;
    logic signed [SC_W-1:0]    psc_reg, psc_next;
    logic signed [SC_W-1:0]    tsc_reg, tsc_next;
    logic signed [MUL_A_W-1:0] x_reg, x_next;
    logic signed [SUM_W-1:0]   p_reg, p_next;
    logic signed [T256_W-1:0]  t256_reg, t256_next;
    logic [P16_W-1:0]          p16_reg, p16_next;
    logic signed [H_W-1:0]     h_reg, h_next;
    logic [M_TDATA_W-1:0]      out_data_reg, out_data_next;

    logic signed [11:0] c0, c1;
    logic signed [19:0] c00, c10;
    logic signed [15:0] c01, c11, c20, c21, c30;

    div_cmd_t                  div_cmd;
    logic                      div_done;
    logic signed [SC_W-1:0]    div_quo;
    mul_cmd_t                  mul_cmd;
    logic                      mul_done;
    logic signed [MUL_A_W-1:0] mul_res;

    logic signed [RAW_W-1:0]   d4;
    logic signed [SUM_W-1:0]   d4_ext;
    logic signed [SUM_W-1:0]   wb_base;
    logic signed [SUM_W-1:0]   wb_sum;
    logic signed [SUM_W-1:0]   p_sh;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [DIFF_W-1:0]  alt_sh;
    logic signed [ALT_W-1:0]   alt;

    assign c0  = calib_low_reg[63:52];
    assign c1  = calib_low_reg[51:40];
    assign c00 = calib_low_reg[39:20];
    assign c10 = calib_low_reg[19:0];
    assign c01 = calib_high_reg[63:48];
    assign c11 = calib_high_reg[47:32];
    assign c20 = calib_high_reg[31:16];
    assign c21 = calib_high_reg[15:0];
    assign c30 = c30_reg;

    assign d4     = D4_BASE - $signed({2'b00, p16_reg});
    assign d4_ext = SUM_W'(d4);

    bpc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .done  (div_done),
        .quo   (div_quo)
    );

    bpc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mul_cmd),
        .done  (mul_done),
        .res   (mul_res)
    );

    // multiplier operands per step
    always_comb begin
        mul_cmd.start = (state_reg == S_MUL);
        mul_cmd.a     = x_reg;
        mul_cmd.b     = psc_reg;
        mul_cmd.sh    = SH_26;
        case (step_reg)
            ST_TEMP: begin
                mul_cmd.a  = MUL_A_W'(c1);
                mul_cmd.b  = tsc_reg;
                mul_cmd.sh = SH_18;
            end
            ST_Q1:   mul_cmd.a = MUL_A_W'(c30) <<< COEF_SHIFT;
            ST_T1:   mul_cmd.a = MUL_A_W'(c21) <<< COEF_SHIFT;
            ST_T3:   mul_cmd.b = tsc_reg;
            ST_U: begin
                mul_cmd.a = MUL_A_W'(c01) <<< COEF_SHIFT;
                mul_cmd.b = tsc_reg;
            end
            ST_SQ: begin
                mul_cmd.a  = MUL_A_W'(d4);
                mul_cmd.b  = MUL_B_W'(d4);
                mul_cmd.sh = SH_8;
            end
            ST_CUBE: begin
                mul_cmd.b  = MUL_B_W'(d4);
                mul_cmd.sh = SH_20;
            end
            ST_H: begin
                mul_cmd.b  = H_CUBE_K;
                mul_cmd.sh = SH_24;
            end
            default: mul_cmd.a = x_reg;
        endcase
    end

    // addend for the step's write-back
    always_comb begin
        case (step_reg)
            ST_TEMP: wb_base = SUM_W'(c0) <<< 7;
            ST_Q1:   wb_base = SUM_W'(c20) <<< COEF_SHIFT;
            ST_Q2:   wb_base = SUM_W'(c10) <<< COEF_SHIFT;
            ST_Q3:   wb_base = SUM_W'(c00) <<< COEF_SHIFT;
            ST_T1:   wb_base = SUM_W'(c11) <<< COEF_SHIFT;
            ST_T3:   wb_base = p_reg;
            ST_U:    wb_base = p_reg;
            ST_H:    wb_base = (d4_ext <<< 7) + (d4_ext <<< 4);
            default: wb_base = '0;
        endcase
    end

    assign wb_sum = wb_base + SUM_W'(mul_res);
    assign p_sh   = p_reg >>> P_SHIFT;
    assign diff   = DIFF_W'(h_reg) - DIFF_W'(offset_reg);
    assign alt_sh = diff >>> ALT_SHIFT;

    always_comb begin
        if (alt_sh < ALT_MIN) begin
            alt = {1'b1, {(ALT_W-1){1'b0}}};
        end
        else if (alt_sh > ALT_MAX) begin
            alt = {1'b0, {(ALT_W-1){1'b1}}};
        end
        else begin
            alt = alt_sh[ALT_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        offset_next    = offset_reg;
        action_next    = action_reg;
        raw_t_next     = raw_t_reg;
        psc_next       = psc_reg;
        tsc_next       = tsc_reg;
        x_next         = x_reg;
        p_next         = p_reg;
        t256_next      = t256_reg;
        p16_next       = p16_reg;
        h_next         = h_reg;
        out_data_next  = out_data_reg;
        div_cmd.start  = 1'b0;
        div_cmd.raw    = raw_t_reg;
        div_cmd.code   = t_osr_reg;
        s_tready       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_tready     = 1'b1;
                div_cmd.raw  = s_tdata[RAW_W-1:0];
                div_cmd.code = p_osr_reg;
                if (s_tvalid) begin
                    div_cmd.start = 1'b1;
                    action_next   = s_tuser;
                    raw_t_next    = s_tdata[S_TDATA_W-1:RAW_W];
                    state_next    = S_DIV_P;
                end
            end
            S_DIV_P: begin
                if (div_done) begin
                    psc_next      = div_quo;
                    div_cmd.start = 1'b1;
                    state_next    = S_DIV_T;
                end
            end
            S_DIV_T: begin
                if (div_done) begin
                    tsc_next   = div_quo;
                    step_next  = ST_TEMP;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (mul_done) begin
                    case (step_reg)
                        ST_TEMP: begin
                            if (wb_sum < T256_MIN) begin
                                t256_next = {1'b1, {(T256_W-1){1'b0}}};
                            end
                            else if (wb_sum > T256_MAX) begin
                                t256_next = {1'b0, {(T256_W-1){1'b1}}};
                            end
                            else begin
                                t256_next = wb_sum[T256_W-1:0];
                            end
                        end
                        ST_Q1, ST_Q2, ST_T1: x_next = sat53(ACC_W'(wb_sum));
                        ST_Q3, ST_T3, ST_U:  p_next = wb_sum;
                        ST_H: begin
                            if (wb_sum < H_MIN) begin
                                h_next = {1'b1, {(H_W-1){1'b0}}};
                            end
                            else if (wb_sum > H_MAX) begin
                                h_next = {1'b0, {(H_W-1){1'b1}}};
                            end
                            else begin
                                h_next = wb_sum[H_W-1:0];
                            end
                        end
                        default: x_next = mul_res;
                    endcase
                    if (step_reg == ST_U) begin
                        state_next = S_PRES;
                    end
                    else if (step_reg == ST_H) begin
                        state_next = S_ALT;
                    end
                    else begin
                        step_next  = step_t'(step_reg + 4'd1);
                        state_next = S_MUL;
                    end
                end
            end
            S_PRES: begin
                if (p_sh < 0) begin
                    p16_next = '0;
                end
                else if (p_sh > P16_MAX) begin
                    p16_next = '1;
                end
                else begin
                    p16_next = p_sh[P16_W-1:0];
                end
                step_next  = ST_SQ;
                state_next = S_MUL;
            end
            S_ALT: begin
                // wait for the output register to free up
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    if (action_reg) begin
                        offset_next   = h_reg;
                        out_data_next = {M_PAD_W'(0), ALT_W'(0), t256_reg, p16_reg};
                    end
                    else begin
                        out_data_next = {M_PAD_W'(0), alt, t256_reg, p16_reg};
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            step_reg      <= ST_TEMP;
            out_valid_reg <= 1'b0;
            offset_reg    <= '0;
        end
        else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            offset_reg    <= offset_next;
        end
    end

    always_ff @(posedge clk) begin
        action_reg   <= action_next;
        raw_t_reg    <= raw_t_next;
        psc_reg      <= psc_next;
        tsc_reg      <= tsc_next;
        x_reg        <= x_next;
        p_reg        <= p_next;
        t256_reg     <= t256_next;
        p16_reg      <= p16_next;
        h_reg        <= h_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            calib_low_reg  <= '0;
            calib_high_reg <= '0;
            c30_reg        <= '0;
            p_osr_reg      <= P_OSR_RESET;
            t_osr_reg      <= T_OSR_RESET;
        end
        else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_CALIB_LOW:  calib_low_reg  <= cfg_data;
                REG_CALIB_HIGH: calib_high_reg <= cfg_data;
                REG_C30:        c30_reg        <= cfg_data[C30_W-1:0];
                REG_P_OSR:      p_osr_reg      <= cfg_data[OSR_W-1:0];
                REG_T_OSR:      t_osr_reg      <= cfg_data[OSR_W-1:0];
                default:        c30_reg        <= c30_reg;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/bpc_chk.sv -----
`default_nettype none

`include "baro_pressure_compensation_altitude_assert.svh"

module bpc_chk (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [bpc_pkg::M_TDATA_W-1:0] m_tdata
);

    // a stalled result holds
    `BPC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // accepting a transaction makes the block busy
    `BPC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // a new result only appears at the end of a computation
    `BPC_ASSERT_NOW(a_result_after_work, clk, rst_n, $rose(m_tvalid), !$past(s_tready))

endmodule

bind baro_pressure_compensation_altitude bpc_chk u_bpc_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- test/baro_pressure_compensation_altitude_tb.sv -----
`timescale 1ns / 1ps

module baro_pressure_compensation_altitude_tb;
    import bpc_pkg::*;

    localparam int LIMIT_CYCLES  = 600000;
    localparam int LONG_HOLD     = 1500;
    localparam int HOLD_AT_A     = 60;
    localparam int HOLD_AT_B     = 330;
    localparam int SETTLE_CYCLES = 250;
    localparam int MAX_PRINTED   = 30;

    localparam int T_LSB   = P16_W;
    localparam int A_LSB   = P16_W + T256_W;
    localparam int PAD_LSB = A_LSB + ALT_W;

    localparam longint SAT_Q    = 64'sh001F_FFFF_FFFF_FFFF;
    localparam longint INT32_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint INT32_LO = -64'sh0000_0000_8000_0000;

    // calibration sets: {c0, c1, c00, c10}, {c01, c11, c20, c21}, c30
    localparam logic [63:0] CAL_LO_TYP = {12'sd204, -12'sd260, 20'sd80000, -20'sd40000};
    localparam logic [63:0] CAL_HI_TYP = {-16'sd2000, 16'sd1000, -16'sd12000, 16'sd150};
    localparam logic [15:0] C30_TYP    = -16'sd1500;
    localparam logic [63:0] CAL_LO_POS = {12'h7FF, 12'h7FF, 20'h7FFFF, 20'h7FFFF};
    localparam logic [63:0] CAL_HI_POS = {4{16'h7FFF}};
    localparam logic [15:0] C30_POS    = 16'h7FFF;
    localparam logic [63:0] CAL_LO_NEG = {12'h800, 12'h800, 20'h80000, 20'h80000};
    localparam logic [63:0] CAL_HI_NEG = {4{16'h8000}};
    localparam logic [15:0] C30_NEG    = 16'h8000;

    localparam logic [RAW_W-1:0] RAW_MAX  = 24'h7FFFFF;
    localparam logic [RAW_W-1:0] RAW_MIN  = 24'h800000;
    localparam logic [RAW_W-1:0] RAW_ONES = 24'hFFFFFF;
    localparam logic [RAW_W-1:0] P_TYP    = -24'sd165000;
    localparam logic [RAW_W-1:0] T_TYP    = 24'sd2000000;

    typedef struct packed {
        logic             zero_ref;
        logic [RAW_W-1:0] raw_p;
        logic [RAW_W-1:0] raw_t;
    } sample_t;

    typedef struct packed {
        logic [P16_W-1:0]         p16;
        logic signed [T256_W-1:0] t256;
        logic signed [ALT_W-1:0]  alt;
    } reading_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // copy of the block's registers and zero reference
    logic [63:0]      cal_lo_m;
    logic [63:0]      cal_hi_m;
    logic [15:0]      c30_m;
    logic [OSR_W-1:0] posr_m;
    logic [OSR_W-1:0] tosr_m;
    int               ref_height;

    sample_t  sample_q[$];
    reading_t reading_q[$];
    sample_t  cur_sample;

    int n_pushed   = 0;
    int n_accepted = 0;
    int n_results  = 0;
    int n_errors   = 0;
    int n_writes   = 0;
    int n_zeroing  = 0;
    int n_cycles   = 0;
    int src_gap    = 0;
    int stall_left = 0;
    bit quiet      = 1'b0;

    baro_pressure_compensation_altitude dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint sat_q(longint v);
        return clip(v, -SAT_Q, SAT_Q);
    endfunction

    // floor(a * s / 2^26) without overflow, split at the fraction bits
    function automatic longint q26_product(longint a, longint s);
        longint hi;
        longint lo;
        hi = a >>> 26;
        lo = a - hi * 64'sd67108864;
        return sat_q(hi * s + ((lo * s) >>> 26));
    endfunction

    function automatic longint osr_divisor(logic [OSR_W-1:0] code);
        case (code)
            3'd0:    return 524288;
            3'd1:    return 1572864;
            3'd2:    return 3670016;
            3'd3:    return 7864320;
            3'd4:    return 253952;
            3'd5:    return 516096;
            3'd6:    return 1040384;
            default: return 2088960;
        endcase
    endfunction

    function automatic longint scale_raw(logic [RAW_W-1:0] raw, logic [OSR_W-1:0] code);
        longint r;
        r = longint'($signed(raw));
        return clip((r * 64'sd67108864) / osr_divisor(code), INT32_LO, INT32_HI);
    endfunction

    function automatic reading_t compensate_sample(sample_t smp);
        longint c0, c1, c00, c10, c01, c11, c20, c21, c30;
        longint psc, tsc, t256, q, t, u, p, p16, d4, cube, h, alt;
        reading_t r;
        c0  = longint'($signed(cal_lo_m[63:52]));
        c1  = longint'($signed(cal_lo_m[51:40]));
        c00 = longint'($signed(cal_lo_m[39:20]));
        c10 = longint'($signed(cal_lo_m[19:0]));
        c01 = longint'($signed(cal_hi_m[63:48]));
        c11 = longint'($signed(cal_hi_m[47:32]));
        c20 = longint'($signed(cal_hi_m[31:16]));
        c21 = longint'($signed(cal_hi_m[15:0]));
        c30 = longint'($signed(c30_m));
        psc = scale_raw(smp.raw_p, posr_m);
        tsc = scale_raw(smp.raw_t, tosr_m);

        t256 = clip(c0 * 128 + ((c1 * tsc) >>> 18), -32768, 32767);

        q = sat_q(c20 * 65536 + q26_product(c30 * 65536, psc));
        q = sat_q(c10 * 65536 + q26_product(q, psc));
        q = q26_product(q, psc);
        t = sat_q(c11 * 65536 + q26_product(c21 * 65536, psc));
        t = q26_product(q26_product(t, psc), tsc);
        u = q26_product(c01 * 65536, tsc);
        p = c00 * 65536 + q + t + u;
        p16 = clip(p >>> 12, 0, 4194303);

        // height in cm, 8 fraction bits, from the pressure drop below sea level
        d4 = 1616000 - p16;
        cube = ((d4 * d4) >>> 8) * d4;
        h = clip(144 * d4 + (((cube >>> 20) * 230808) >>> 24), INT32_LO, INT32_HI);

        if (smp.zero_ref)
        begin
            ref_height = int'(h);
            alt = 0;
        end
        else
        begin
            alt = clip((h - longint'(ref_height)) >>> 8, -4194304, 4194303);
        end

        r.p16  = p16[P16_W-1:0];
        r.t256 = t256[T256_W-1:0];
        r.alt  = alt[ALT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        n_errors++;
        if (n_errors <= MAX_PRINTED)
            $display("mismatch on %s, transaction %0d: got %0d, expected %0d",
                     what, n_results, got, want);
    endtask

    task automatic check_reading(logic [M_TDATA_W-1:0] word);
        reading_t want;
        if (reading_q.size() == 0)
        begin
            report_mismatch("unrequested result", longint'(word[PAD_LSB-1:0]), 0);
        end
        else
        begin
            want = reading_q.pop_front();
            if (word[P16_W-1:0] !== want.p16)
                report_mismatch("pressure_x16", word[P16_W-1:0], want.p16);
            if (word[T_LSB +: T256_W] !== want.t256)
                report_mismatch("temperature_x256", longint'($signed(word[T_LSB +: T256_W])),
                                want.t256);
            if (word[A_LSB +: ALT_W] !== want.alt)
                report_mismatch("altitude_cm", longint'($signed(word[A_LSB +: ALT_W])),
                                want.alt);
            if (word[M_TDATA_W-1:PAD_LSB] !== '0)
                report_mismatch("pad bits", word[M_TDATA_W-1:PAD_LSB], 0);
            n_results++;
        end
    endtask

    // source side: presents queued samples, predicts each accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                reading_q.push_back(compensate_sample(cur_sample));
                n_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (sample_q.size() > 0)
                begin
                    cur_sample = sample_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_sample.raw_t, cur_sample.raw_p};
                    s_tuser  <= cur_sample.zero_ref;
                    if (!quiet && $urandom_range(0, 3) == 0)
                        src_gap = $urandom_range(1, 10);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side: checks results, stalls in bursts and twice for a long stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_reading(m_tdata);
                if (n_results == HOLD_AT_A || n_results == HOLD_AT_B)
                    stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > LIMIT_CYCLES)
        begin
            $display("timeout: %0d of %0d transactions finished", n_results, n_pushed);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_CALIB_LOW:  cal_lo_m = val;
            REG_CALIB_HIGH: cal_hi_m = val;
            REG_C30:        c30_m = val[15:0];
            REG_P_OSR:      posr_m = val[OSR_W-1:0];
            REG_T_OSR:      tosr_m = val[OSR_W-1:0];
            default:        ;
        endcase
        n_writes++;
    endtask

    // writes every register, unused upper bits and unmapped indexes get junk
    task automatic load_setup(logic [63:0] lo, logic [63:0] hi, logic [15:0] c30,
                              logic [OSR_W-1:0] p_code, logic [OSR_W-1:0] t_code);
        logic [63:0] junk;
        write_reg(REG_CALIB_LOW, lo);
        write_reg(REG_CALIB_HIGH, hi);
        junk = {$urandom(), $urandom()};
        write_reg(REG_C30, {junk[63:16], c30});
        junk = {$urandom(), $urandom()};
        write_reg(REG_P_OSR, {junk[63:OSR_W], p_code});
        junk = {$urandom(), $urandom()};
        write_reg(REG_T_OSR, {junk[63:OSR_W], t_code});
        for (int i = int'(REG_T_OSR) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(i[CFG_IDX_W-1:0], {$urandom(), $urandom()});
    endtask

    task automatic push_sample(logic zero_ref, logic [RAW_W-1:0] rp, logic [RAW_W-1:0] rt);
        sample_t smp;
        smp.zero_ref = zero_ref;
        smp.raw_p = rp;
        smp.raw_t = rt;
        sample_q.push_back(smp);
        n_pushed++;
        if (zero_ref)
            n_zeroing++;
    endtask

    // mostly plausible readings for the current oversampling, some raw noise
    task automatic push_random();
        longint kp;
        longint kt;
        logic [RAW_W-1:0] rp;
        logic [RAW_W-1:0] rt;
        kp = osr_divisor(posr_m);
        kt = osr_divisor(tosr_m);
        if ($urandom_range(0, 9) < 8)
        begin
            rp = RAW_W'(-(kp * longint'($urandom_range(300, 950)) / 1000));
            rt = RAW_W'(kt * (longint'($urandom_range(0, 1000)) - 500) / 1000);
        end
        else
        begin
            rp = RAW_W'($urandom());
            rt = RAW_W'($urandom());
        end
        push_sample($urandom_range(0, 7) == 0, rp, rt);
    endtask

    task automatic drain();
        while (n_results != n_pushed)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            push_random();
        drain();
    endtask

    initial
    begin
        cal_lo_m   = '0;
        cal_hi_m   = '0;
        c30_m      = '0;
        posr_m     = P_OSR_RESET;
        tosr_m     = T_OSR_RESET;
        ref_height = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // calibration still zero after reset
        push_sample(1'b0, '0, '0);
        push_sample(1'b0, RAW_MAX, RAW_MAX);
        push_sample(1'b1, RAW_MIN, RAW_MIN);
        push_sample(1'b0, RAW_ONES, 24'h5A5A5A);
        drain();

        load_setup(CAL_LO_TYP, CAL_HI_TYP, C30_TYP, 3'd4, 3'd3);
        push_sample(1'b0, P_TYP, T_TYP);
        push_sample(1'b1, P_TYP, T_TYP);
        push_sample(1'b0, P_TYP, T_TYP);
        push_sample(1'b0, -24'sd170000, T_TYP);
        push_sample(1'b0, -24'sd150000, T_TYP);
        push_sample(1'b0, RAW_MAX, T_TYP);
        push_sample(1'b0, RAW_MIN, T_TYP);
        push_sample(1'b0, RAW_ONES, T_TYP);
        push_sample(1'b0, '0, '0);
        push_sample(1'b0, P_TYP, RAW_MAX);
        push_sample(1'b0, P_TYP, RAW_MIN);
        // reference taken at the extreme, then altitudes far away from it
        push_sample(1'b1, RAW_MIN, T_TYP);
        push_sample(1'b0, P_TYP, T_TYP);
        push_sample(1'b0, RAW_MAX, T_TYP);
        push_sample(1'b1, P_TYP, T_TYP);
        push_sample(1'b0, RAW_MIN, RAW_MAX);
        push_sample(1'b1, RAW_ONES, RAW_ONES);
        push_sample(1'b0, P_TYP, T_TYP);
        drain();

        // the first long sink hold falls inside this phase
        run_random(70);
        load_setup(CAL_LO_TYP, CAL_HI_TYP, C30_TYP, 3'd0, 3'd7);
        run_random(60);
        load_setup(CAL_LO_TYP, CAL_HI_TYP, C30_TYP, 3'd7, 3'd0);
        run_random(60);
        load_setup({$urandom(), $urandom()}, {$urandom(), $urandom()}, 16'($urandom()),
                   3'd6, 3'd1);
        run_random(60);
        load_setup(CAL_LO_POS, CAL_HI_POS, C30_POS, 3'd3, 3'd4);
        run_random(50);
        load_setup(CAL_LO_NEG, CAL_HI_NEG, C30_NEG, 3'd5, 3'd6);
        run_random(50);
        load_setup('1, '1, '1, 3'd1, 3'd2);
        run_random(50);

        quiet = 1'b1;
        load_setup(CAL_LO_TYP, CAL_HI_TYP, C30_TYP, 3'd2, 3'd5);
        run_random(120);

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("%0d transactions checked, %0d of them zeroing the reference, %0d reg writes",
                 n_results, n_zeroing, n_writes);
        $display("calibration zero, typical, random, full-scale and all ones; all osr codes");
        if (reading_q.size() != 0)
            $display("%0d transactions never produced a result", reading_q.size());
        if (n_errors == 0 && reading_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
